FILE: hw/rtl/sensor_frame_receiver_assert.svh
// Assertion macros for the sensor frame receiver.
// Included by the top level; depends on nothing else.
`ifndef SENSOR_FRAME_RECEIVER_ASSERT_SVH
`define SENSOR_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SFR_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sensor frame receiver: implication failed");

// Next-cycle implication, disabled during reset.
`define SFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sensor frame receiver: next-cycle check failed");

`endif

FILE: hw/rtl/sfr_pkg.sv
// Shared types, codes and the CRC-8 byte update for the sensor frame receiver.
// No dependencies.
`timescale 1ns / 1ps

package sfr_pkg;

   typedef logic [7:0]  byte_type;
   typedef logic [2:0]  status_type;
   typedef logic [2:0]  pos_type;
   typedef logic [15:0] altitude_type;

   // Frame markers and CRC polynomial
   localparam byte_type HEAD_BYTE = 8'h55;
   localparam byte_type TAIL_BYTE = 8'haa;
   localparam byte_type DATA_KEY  = 8'h07;
   localparam byte_type CRC_POLY  = 8'h31;

   // Byte positions within a frame
   localparam pos_type POS_HEAD  = 3'd0;
   localparam pos_type POS_KEY   = 3'd1;
   localparam pos_type POS_VAL3  = 3'd2;
   localparam pos_type POS_VAL2  = 3'd3;
   localparam pos_type POS_VAL1  = 3'd4;
   localparam pos_type POS_VAL0  = 3'd5;
   localparam pos_type POS_CRC   = 3'd6;
   localparam pos_type POS_TAIL  = 3'd7;

   // Frame status codes
   localparam status_type ST_NORMAL    = 3'd0;
   localparam status_type ST_RANGE     = 3'd1;
   localparam status_type ST_BAD_FRAME = 3'd2;
   localparam status_type ST_BAD_CRC   = 3'd3;
   localparam status_type ST_OTHER_KEY = 3'd4;

   // CRC-8, MSB first, one byte per call
   function automatic byte_type crc8_byte(input byte_type crc, input byte_type data);
      byte_type c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

FILE: hw/rtl/sfr_if.sv
// Valid/ready channel interfaces for the sensor frame receiver.
// Depends on sfr_pkg.
`timescale 1ns / 1ps

// Received byte channel
interface sfr_req_if;
   import sfr_pkg::*;
   logic     valid;
   logic     ready;
   byte_type rx_byte;
   logic     frame_start;

   modport source (output valid, output rx_byte, output frame_start, input ready);
   modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

// Frame status channel
interface sfr_rsp_if;
   import sfr_pkg::*;
   logic         valid;
   logic         ready;
   status_type   frame_status;
   altitude_type altitude;
   logic         updated;

   modport source (output valid, output frame_status, output altitude, output updated,
                   input ready);
   modport sink   (input valid, input frame_status, input altitude, input updated,
                   output ready);
endinterface

FILE: hw/rtl/sensor_frame_receiver.sv
// Sensor frame receiver: frames 8-byte sensor packets, checks head, tail and
// CRC-8 (poly 0x31, init 0) and keeps the last altitude reading. Takes one
// received byte per beat and gives one status beat on the eighth byte of a
// frame. A byte with frame_start set restarts the byte count at the head.
// Throughput is one byte per clock while the output is not stalled; each
// byte passes an input register and the eighth one lands in the result
// register, so a status follows its tail byte through both registers, and
// waits longer while an earlier status is untaken. The per-byte CRC update
// is an unrolled XOR network between the input and CRC registers. The input
// side stalls only while a tail byte waits behind an untaken result.
// Depends on sfr_pkg, sfr_if and sensor_frame_receiver_assert.svh.
`timescale 1ns / 1ps
`include "sensor_frame_receiver_assert.svh"

module sensor_frame_receiver (
   input logic clock,
   input logic reset,
   sfr_req_if.sink   req_chan,
   sfr_rsp_if.source rsp_chan
);
   import sfr_pkg::*;

   // Input register
   logic     s1_valid_ff, s1_valid_in;
   byte_type s1_byte_ff, s1_byte_in;
   logic     s1_start_ff, s1_start_in;

   // Frame state
   pos_type      byte_index_ff, byte_index_in;
   byte_type     crc_ff, crc_in;
   logic         head_ok_ff, head_ok_in;
   logic         key_data_ff, key_data_in;
   logic         top_zero_ff, top_zero_in;
   altitude_type low_bytes_ff, low_bytes_in;
   logic         crc_match_ff, crc_match_in;
   altitude_type altitude_ff, altitude_in;

   // Result register
   logic         rsp_valid_ff, rsp_valid_in;
   status_type   rsp_status_ff, rsp_status_in;
   altitude_type rsp_alt_ff, rsp_alt_in;
   logic         rsp_upd_ff, rsp_upd_in;

   pos_type  pos;
   logic     is_last;
   logic     out_free;
   logic     s1_go;
   logic     req_take;
   byte_type crc_next;

   // Handshake and advance control
   assign pos      = s1_start_ff ? POS_HEAD : byte_index_ff;
   assign is_last  = (pos == POS_TAIL);
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign s1_go    = s1_valid_ff && (!is_last || out_free);
   assign req_chan.ready = !s1_valid_ff || s1_go;
   assign req_take = req_chan.valid && req_chan.ready;
   assign crc_next = crc8_byte(crc_ff, s1_byte_ff);

   // Load the input register
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_byte_in  = s1_byte_ff;
      s1_start_in = s1_start_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
         s1_byte_in  = req_chan.rx_byte;
         s1_start_in = req_chan.frame_start;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
   end

   // Advance the frame state and build the status beat
   always_comb begin
      byte_index_in = byte_index_ff;
      crc_in        = crc_ff;
      head_ok_in    = head_ok_ff;
      key_data_in   = key_data_ff;
      top_zero_in   = top_zero_ff;
      low_bytes_in  = low_bytes_ff;
      crc_match_in  = crc_match_ff;
      altitude_in   = altitude_ff;
      rsp_status_in = rsp_status_ff;
      rsp_alt_in    = rsp_alt_ff;
      rsp_upd_in    = rsp_upd_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      if (s1_go) begin
         byte_index_in = pos + 3'd1;
         case (pos)
            POS_HEAD: begin
               head_ok_in = (s1_byte_ff == HEAD_BYTE);
               crc_in     = '0;
            end
            POS_KEY: begin
               key_data_in = (s1_byte_ff == DATA_KEY);
               crc_in      = crc_next;
            end
            POS_VAL3: begin
               top_zero_in = (s1_byte_ff == 8'h00);
               crc_in      = crc_next;
            end
            POS_VAL2: begin
               crc_in = crc_next;
            end
            POS_VAL1: begin
               low_bytes_in = {s1_byte_ff, low_bytes_ff[7:0]};
               crc_in       = crc_next;
            end
            POS_VAL0: begin
               low_bytes_in = {low_bytes_ff[15:8], s1_byte_ff};
               crc_in       = crc_next;
            end
            POS_CRC: begin
               crc_match_in = (s1_byte_ff == crc_ff);
            end
            default: begin
               // Tail byte: judge the frame and emit one beat
               rsp_valid_in = 1'b1;
               rsp_upd_in   = 1'b0;
               if (!head_ok_ff || (s1_byte_ff != TAIL_BYTE)) begin
                  rsp_status_in = ST_BAD_FRAME;
               end else if (!crc_match_ff) begin
                  rsp_status_in = ST_BAD_CRC;
               end else if (!key_data_ff) begin
                  rsp_status_in = ST_OTHER_KEY;
               end else if (top_zero_ff) begin
                  rsp_status_in = ST_NORMAL;
                  altitude_in   = low_bytes_ff;
                  rsp_upd_in    = 1'b1;
               end else begin
                  rsp_status_in = ST_RANGE;
                  altitude_in   = '0;
                  rsp_upd_in    = 1'b1;
               end
               rsp_alt_in = altitude_in;
            end
         endcase
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         byte_index_ff <= '0;
         crc_ff        <= '0;
         head_ok_ff    <= 1'b0;
         key_data_ff   <= 1'b0;
         top_zero_ff   <= 1'b0;
         low_bytes_ff  <= '0;
         crc_match_ff  <= 1'b0;
         altitude_ff   <= '0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         byte_index_ff <= byte_index_in;
         crc_ff        <= crc_in;
         head_ok_ff    <= head_ok_in;
         key_data_ff   <= key_data_in;
         top_zero_ff   <= top_zero_in;
         low_bytes_ff  <= low_bytes_in;
         crc_match_ff  <= crc_match_in;
         altitude_ff   <= altitude_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      s1_byte_ff    <= s1_byte_in;
      s1_start_ff   <= s1_start_in;
      rsp_status_ff <= rsp_status_in;
      rsp_alt_ff    <= rsp_alt_in;
      rsp_upd_ff    <= rsp_upd_in;
   end

   // Drive the result channel
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.frame_status = rsp_status_ff;
   assign rsp_chan.altitude     = rsp_alt_ff;
   assign rsp_chan.updated      = rsp_upd_ff;

   // Checks
   `SFR_ASSERT_IMPLY(a_stall_only_on_output, clock, reset, s1_valid_ff && !s1_go,
      rsp_valid_ff && !rsp_chan.ready)
   `SFR_ASSERT_NEXT(a_tail_gives_beat, clock, reset, s1_go && is_last, rsp_valid_ff)
   `SFR_ASSERT_IMPLY(a_reject_no_update, clock, reset, rsp_valid_ff && !rsp_upd_ff,
      rsp_status_ff == ST_BAD_FRAME || rsp_status_ff == ST_BAD_CRC ||
      rsp_status_ff == ST_OTHER_KEY)
   `SFR_ASSERT_IMPLY(a_range_zeroes_alt, clock, reset,
      rsp_valid_ff && rsp_status_ff == ST_RANGE, rsp_alt_ff == 16'h0000 && rsp_upd_ff)

endmodule
